[sv/jnv_pkg.sv]
// Package for the JSON number validator: item types, phase and verdict codes, grammar step.
package jnv_pkg;

    localparam int unsigned CpWidth    = 21;
    localparam int unsigned LimitWidth = 16;
    localparam int unsigned CountWidth = 16;

    typedef logic [CpWidth-1:0]    cp_t;
    typedef logic [LimitWidth-1:0] limit_t;
    typedef logic [CountWidth-1:0] count_t;
    typedef logic [3:0]            phase_t;
    typedef logic [1:0]            verdict_t;

    // Grammar positions
    localparam phase_t PH_START   = 4'd0;
    localparam phase_t PH_MINUS   = 4'd1;
    localparam phase_t PH_ZERO    = 4'd2;
    localparam phase_t PH_INT     = 4'd3;
    localparam phase_t PH_DOT     = 4'd4;
    localparam phase_t PH_FRAC    = 4'd5;
    localparam phase_t PH_EXP     = 4'd6;
    localparam phase_t PH_EXPSIGN = 4'd7;
    localparam phase_t PH_EXPDIG  = 4'd8;
    localparam phase_t PH_BAD     = 4'd15;

    // Verdict codes
    localparam verdict_t V_PENDING = 2'd0;
    localparam verdict_t V_VALID   = 2'd1;
    localparam verdict_t V_INVALID = 2'd2;
    localparam verdict_t V_IDLE    = 2'd3;

    // Characters
    localparam cp_t CH_MINUS = 21'h2D;
    localparam cp_t CH_PLUS  = 21'h2B;
    localparam cp_t CH_ZERO  = 21'h30;
    localparam cp_t CH_NINE  = 21'h39;
    localparam cp_t CH_DOT   = 21'h2E;
    localparam cp_t CH_LO_E  = 21'h65;
    localparam cp_t CH_UP_E  = 21'h45;
    localparam cp_t CH_COMMA = 21'h2C;
    localparam cp_t CH_RBRK  = 21'h5D;
    localparam cp_t CH_SPACE = 21'h20;
    localparam cp_t CH_TAB   = 21'h09;
    localparam cp_t CH_LF    = 21'h0A;
    localparam cp_t CH_CR    = 21'h0D;

    localparam count_t COUNT_MAX = '1;

    // One registered request
    typedef struct packed {
        cp_t  code_point;
        logic first;
        logic last;
    } item_t;

    function automatic logic is_digit(input cp_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_blank(input cp_t c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_complete(input phase_t p);
        return (p == PH_ZERO) || (p == PH_INT) || (p == PH_FRAC) || (p == PH_EXPDIG);
    endfunction

    // One grammar step; PH_BAD when the character breaks the grammar
    function automatic phase_t next_phase(input phase_t p, input cp_t c);
        logic   dig;
        logic   expmark;
        phase_t np;
        dig     = is_digit(c);
        expmark = (c == CH_LO_E) || (c == CH_UP_E);
        np      = PH_BAD;
        unique case (p)
            PH_START:
            begin
                if (c == CH_MINUS)     np = PH_MINUS;
                else if (c == CH_ZERO) np = PH_ZERO;
                else if (dig)          np = PH_INT;
            end
            PH_MINUS:
            begin
                if (c == CH_ZERO) np = PH_ZERO;
                else if (dig)     np = PH_INT;
            end
            PH_ZERO:
            begin
                if (c == CH_DOT)   np = PH_DOT;
                else if (expmark)  np = PH_EXP;
            end
            PH_INT:
            begin
                if (dig)                np = PH_INT;
                else if (c == CH_DOT)   np = PH_DOT;
                else if (expmark)       np = PH_EXP;
            end
            PH_DOT:
            begin
                if (dig) np = PH_FRAC;
            end
            PH_FRAC:
            begin
                if (dig)          np = PH_FRAC;
                else if (expmark) np = PH_EXP;
            end
            PH_EXP:
            begin
                if ((c == CH_PLUS) || (c == CH_MINUS)) np = PH_EXPSIGN;
                else if (dig)                          np = PH_EXPDIG;
            end
            PH_EXPSIGN, PH_EXPDIG:
            begin
                if (dig) np = PH_EXPDIG;
            end
            default:
            begin
                np = PH_BAD;
            end
        endcase
        return np;
    endfunction

endpackage

[sv/jnv_if.sv]
// Channel interfaces for the JSON number validator: character requests and verdicts.
interface jnv_in_if;
    logic             valid;
    logic             ready;
    jnv_pkg::cp_t     code_point;
    logic             first;
    logic             last;

    modport source (output valid, output code_point, output first, output last, input ready);
    modport sink   (input valid, input code_point, input first, input last, output ready);
endinterface

interface jnv_out_if;
    logic              valid;
    logic              ready;
    jnv_pkg::verdict_t verdict;
    logic              ended_on_terminator;

    modport source (output valid, output verdict, output ended_on_terminator, input ready);
    modport sink   (input valid, input verdict, input ended_on_terminator, output ready);
endinterface

[sv/jnv_in_stage.sv]
// JSON number validator input register: captures one character per cycle unless stalled.
module jnv_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    jnv_in_if.sink          item_in,
    input  logic            take,
    output logic            item_valid,
    output jnv_pkg::item_t  item
);

    logic           valid_reg;
    logic           valid_next;
    jnv_pkg::item_t item_reg;
    logic           accept;

    // Accept while empty or while the held request moves on
    assign item_in.ready = !valid_reg || take;
    assign accept        = item_in.valid && item_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold the payload until replaced
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.code_point <= item_in.code_point;
            item_reg.first      <= item_in.first;
            item_reg.last       <= item_in.last;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[sv/jnv_scan.sv]
// Scanner of the JSON number validator: grammar state, length limit and result register.
module jnv_scan
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  jnv_pkg::limit_t cfg_wdata,
    input  logic            item_valid,
    input  jnv_pkg::item_t  item,
    output logic            take,
    jnv_out_if.source       result_out
);

    localparam jnv_pkg::limit_t LIMIT_RESET = 16'd256;

    jnv_pkg::limit_t   limit_reg;
    jnv_pkg::phase_t   phase_reg, phase_next;
    logic              trail_reg, trail_next;
    jnv_pkg::count_t   count_reg, count_next;
    logic              decided_reg, decided_next;
    logic              out_valid_reg, out_valid_next;
    jnv_pkg::verdict_t verdict_reg, verdict_next;
    logic              term_reg, term_next;

    jnv_pkg::phase_t   cur_phase;
    logic              cur_trail;
    jnv_pkg::count_t   cur_count;
    logic              cur_decided;
    jnv_pkg::phase_t   step_phase;
    logic              is_term;

    // Advance when a request waits and the result slot is free or draining
    assign take = item_valid && (!out_valid_reg || result_out.ready);

    // Scan one character
    always_comb
    begin
        cur_phase   = item.first ? jnv_pkg::PH_START : phase_reg;
        cur_trail   = item.first ? 1'b0 : trail_reg;
        cur_count   = item.first ? '0 : count_reg;
        cur_decided = item.first ? 1'b0 : decided_reg;
        step_phase  = jnv_pkg::next_phase(cur_phase, item.code_point);
        is_term     = (item.code_point == jnv_pkg::CH_COMMA) ||
                      (item.code_point == jnv_pkg::CH_RBRK);

        phase_next   = cur_phase;
        trail_next   = cur_trail;
        count_next   = cur_count;
        decided_next = cur_decided;
        verdict_next = jnv_pkg::V_PENDING;
        term_next    = 1'b0;

        if (cur_decided)
        begin
            verdict_next = jnv_pkg::V_IDLE;
        end
        else
        begin
            if (cur_count != jnv_pkg::COUNT_MAX)
                count_next = cur_count + 1'b1;

            priority if (is_term)
            begin
                verdict_next = jnv_pkg::is_complete(cur_phase) ? jnv_pkg::V_VALID
                                                               : jnv_pkg::V_INVALID;
                term_next    = 1'b1;
            end
            else if (jnv_pkg::is_blank(item.code_point))
            begin
                priority if (cur_trail || (cur_phase == jnv_pkg::PH_START))
                    trail_next = cur_trail;
                else if (jnv_pkg::is_complete(cur_phase))
                    trail_next = 1'b1;
                else
                    verdict_next = jnv_pkg::V_INVALID;
            end
            else if (cur_trail)
            begin
                verdict_next = jnv_pkg::V_INVALID;
            end
            else if (step_phase == jnv_pkg::PH_BAD)
            begin
                verdict_next = jnv_pkg::V_INVALID;
            end
            else
            begin
                phase_next = step_phase;
            end

            // End of buffer or length limit closes the value
            if ((verdict_next == jnv_pkg::V_PENDING) &&
                (item.last || (count_next >= limit_reg)))
                verdict_next = jnv_pkg::is_complete(phase_next) ? jnv_pkg::V_VALID
                                                                : jnv_pkg::V_INVALID;

            if (verdict_next != jnv_pkg::V_PENDING)
                decided_next = 1'b1;
        end
    end

    // Result slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            phase_reg     <= jnv_pkg::PH_START;
            trail_reg     <= 1'b0;
            count_reg     <= '0;
            decided_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (take)
            begin
                phase_reg   <= phase_next;
                trail_reg   <= trail_next;
                count_reg   <= count_next;
                decided_reg <= decided_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            verdict_reg <= verdict_next;
            term_reg    <= term_next;
        end
    end

    assign result_out.valid               = out_valid_reg;
    assign result_out.verdict             = verdict_reg;
    assign result_out.ended_on_terminator = term_reg;

    // A terminator flag comes only with a decision
    a_term_decides: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && term_reg |->
            (verdict_reg == jnv_pkg::V_VALID) || (verdict_reg == jnv_pkg::V_INVALID))
        else $error("terminator flag without a decision");

    // A character after a decision without a restart is idle
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take && decided_reg && !item.first |=> (verdict_reg == jnv_pkg::V_IDLE))
        else $error("character after decision not reported idle");

    // A trailing blank only follows a complete number
    a_trail: assert property (@(posedge clk) disable iff (!rst_n)
        trail_reg |-> jnv_pkg::is_complete(phase_reg))
        else $error("trailing blank on incomplete number");

    // A decision marks the value decided
    a_decided: assert property (@(posedge clk) disable iff (!rst_n)
        take && (verdict_next != jnv_pkg::V_PENDING) |=> decided_reg)
        else $error("decision did not close the value");

endmodule

[sv/json_number_validator_top.sv]
// Top level of the JSON number validator: input register, scanner and result register.
//
//   channel      direction  handshake        payload
//   item_in      in         valid / ready    code_point[20:0], first, last
//   result_out   out        valid / ready    verdict[1:0], ended_on_terminator
//   cfg          in         cfg_we           cfg_wdata[15:0] (length limit)
//
// One request per cycle sustained while the result drains; a taken request passes through
// the input register, then the scan logic into the result register.
// The grammar state updates in the same cycle as the result register loads, so each
// character sees the state left by the one before it.
// Reset (rst_n low) clears the state to idle and the length limit to 256.
// A stalled result holds; the input register still takes a request when the result
// drains in the same cycle.
module json_number_validator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    jnv_in_if.sink      item_in,
    jnv_out_if.source   result_out
);

    logic           take;
    logic           item_valid;
    jnv_pkg::item_t item;

    jnv_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    jnv_scan u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .result_out (result_out)
    );

endmodule

[verif/tb_top.sv]
// JSON number validator testbench: directed and random streams against a scanner model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        jnv_pkg::verdict_t verdict;
        logic              on_term;
    } verdict_rec_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [15:0] cfg_wdata;

    jnv_in_if  chars_in ();
    jnv_out_if verdicts_out ();

    json_number_validator_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_in    (chars_in),
        .result_out (verdicts_out)
    );

    // Scanner model state and its copy of the length limit
    jnv_pkg::phase_t scan_phase = jnv_pkg::PH_START;
    logic            scan_trail = 1'b0;
    jnv_pkg::count_t scan_count = '0;
    logic            scan_done  = 1'b1;
    jnv_pkg::limit_t scan_limit = 16'd256;

    jnv_pkg::item_t pending_chars[$];
    verdict_rec_t   expected_verdicts[$];
    jnv_pkg::cp_t   text_buf[$];

    int   error_count = 0;
    int   src_gap     = 0;
    int   sink_gap    = 0;
    logic idle_on     = 1'b1;
    logic holdoff_go  = 1'b0;
    logic sink_hold   = 1'b0;

    // Clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic number_finished(input jnv_pkg::phase_t p);
        return (p == jnv_pkg::PH_ZERO) || (p == jnv_pkg::PH_INT) ||
               (p == jnv_pkg::PH_FRAC) || (p == jnv_pkg::PH_EXPDIG);
    endfunction

    // Advance the scanner model by one character and return the verdict it gives
    function automatic verdict_rec_t predict_verdict(input jnv_pkg::cp_t c, input logic fresh,
                                                     input logic at_end);
        verdict_rec_t    r;
        logic            dig;
        logic            expm;
        logic            blank;
        logic            whole;
        jnv_pkg::phase_t np;
        r.verdict = jnv_pkg::V_PENDING;
        r.on_term = 1'b0;
        if (fresh)
        begin
            scan_phase = jnv_pkg::PH_START;
            scan_trail = 1'b0;
            scan_count = '0;
            scan_done  = 1'b0;
        end
        if (scan_done)
        begin
            r.verdict = jnv_pkg::V_IDLE;
            return r;
        end
        if (scan_count != jnv_pkg::COUNT_MAX)
            scan_count++;
        dig   = (c >= jnv_pkg::CH_ZERO) && (c <= jnv_pkg::CH_NINE);
        expm  = (c == jnv_pkg::CH_LO_E) || (c == jnv_pkg::CH_UP_E);
        blank = (c == jnv_pkg::CH_SPACE) || (c == jnv_pkg::CH_TAB) ||
                (c == jnv_pkg::CH_LF) || (c == jnv_pkg::CH_CR);
        whole = number_finished(scan_phase);
        if ((c == jnv_pkg::CH_COMMA) || (c == jnv_pkg::CH_RBRK))
        begin
            r.verdict = whole ? jnv_pkg::V_VALID : jnv_pkg::V_INVALID;
            r.on_term = 1'b1;
        end
        else if (blank)
        begin
            // Skip leading blanks; a blank after a full number opens the trailing run
            if (!scan_trail && (scan_phase != jnv_pkg::PH_START))
            begin
                if (whole)
                    scan_trail = 1'b1;
                else
                    r.verdict = jnv_pkg::V_INVALID;
            end
        end
        else if (scan_trail)
        begin
            r.verdict = jnv_pkg::V_INVALID;
        end
        else
        begin
            np = jnv_pkg::PH_BAD;
            case (scan_phase)
                jnv_pkg::PH_START:
                    if (c == jnv_pkg::CH_MINUS) np = jnv_pkg::PH_MINUS;
                    else if (c == jnv_pkg::CH_ZERO) np = jnv_pkg::PH_ZERO;
                    else if (dig) np = jnv_pkg::PH_INT;
                jnv_pkg::PH_MINUS:
                    if (c == jnv_pkg::CH_ZERO) np = jnv_pkg::PH_ZERO;
                    else if (dig) np = jnv_pkg::PH_INT;
                jnv_pkg::PH_ZERO:
                    if (c == jnv_pkg::CH_DOT) np = jnv_pkg::PH_DOT;
                    else if (expm) np = jnv_pkg::PH_EXP;
                jnv_pkg::PH_INT:
                    if (dig) np = jnv_pkg::PH_INT;
                    else if (c == jnv_pkg::CH_DOT) np = jnv_pkg::PH_DOT;
                    else if (expm) np = jnv_pkg::PH_EXP;
                jnv_pkg::PH_DOT:
                    if (dig) np = jnv_pkg::PH_FRAC;
                jnv_pkg::PH_FRAC:
                    if (dig) np = jnv_pkg::PH_FRAC;
                    else if (expm) np = jnv_pkg::PH_EXP;
                jnv_pkg::PH_EXP:
                    if ((c == jnv_pkg::CH_PLUS) || (c == jnv_pkg::CH_MINUS))
                        np = jnv_pkg::PH_EXPSIGN;
                    else if (dig)
                        np = jnv_pkg::PH_EXPDIG;
                jnv_pkg::PH_EXPSIGN, jnv_pkg::PH_EXPDIG:
                    if (dig) np = jnv_pkg::PH_EXPDIG;
                default:
                    np = jnv_pkg::PH_BAD;
            endcase
            if (np == jnv_pkg::PH_BAD)
                r.verdict = jnv_pkg::V_INVALID;
            else
                scan_phase = np;
        end
        // End of buffer or length limit closes a value still open
        if ((r.verdict == jnv_pkg::V_PENDING) && (at_end || (scan_count >= scan_limit)))
            r.verdict = number_finished(scan_phase) ? jnv_pkg::V_VALID : jnv_pkg::V_INVALID;
        if (r.verdict != jnv_pkg::V_PENDING)
            scan_done = 1'b1;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Sender: present queued requests, record the prediction on each handshake
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_in.valid      <= 1'b0;
            chars_in.code_point <= '0;
            chars_in.first      <= 1'b0;
            chars_in.last       <= 1'b0;
            src_gap = 0;
        end
        else if (!chars_in.valid || chars_in.ready)
        begin
            if (chars_in.valid)
                expected_verdicts.push_back(predict_verdict(chars_in.code_point,
                                                            chars_in.first, chars_in.last));
            if ((src_gap == 0) && idle_on && ($urandom_range(0, 7) == 0))
                src_gap = $urandom_range(1, 5);
            if ((src_gap != 0) || (pending_chars.size() == 0))
            begin
                if (src_gap != 0)
                    src_gap--;
                chars_in.valid <= 1'b0;
            end
            else
            begin
                chars_in.valid      <= 1'b1;
                chars_in.code_point <= pending_chars[0].code_point;
                chars_in.first      <= pending_chars[0].first;
                chars_in.last       <= pending_chars[0].last;
                void'(pending_chars.pop_front());
            end
        end
    end

    // Receiver: check each verdict against the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        verdict_rec_t want;
        verdict_rec_t got;
        if (!rst_n)
        begin
            verdicts_out.ready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (verdicts_out.valid && verdicts_out.ready)
            begin
                got.verdict = verdicts_out.verdict;
                got.on_term = verdicts_out.ended_on_terminator;
                if (expected_verdicts.size() == 0)
                begin
                    flag_error($sformatf("verdict %0d term %0b with nothing expected",
                                         got.verdict, got.on_term));
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if ((got.verdict != want.verdict) || (got.on_term != want.on_term))
                        flag_error($sformatf("verdict exp %0d got %0d, term exp %0b got %0b",
                                             want.verdict, got.verdict,
                                             want.on_term, got.on_term));
                end
            end
            if ((sink_gap == 0) && idle_on && ($urandom_range(0, 7) == 0))
                sink_gap = $urandom_range(1, 5);
            if (sink_hold)
            begin
                verdicts_out.ready <= 1'b0;
            end
            else if (sink_gap != 0)
            begin
                sink_gap--;
                verdicts_out.ready <= 1'b0;
            end
            else
            begin
                verdicts_out.ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial
    begin
        wait (holdoff_go);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (60) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // Run limit
    initial
    begin
        #200000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic jnv_pkg::cp_t random_digit(input int lo);
        return jnv_pkg::CH_ZERO + jnv_pkg::cp_t'($urandom_range(lo, 9));
    endfunction

    function automatic jnv_pkg::cp_t random_blank();
        case ($urandom_range(0, 3))
            0: return jnv_pkg::CH_SPACE;
            1: return jnv_pkg::CH_TAB;
            2: return jnv_pkg::CH_LF;
            default: return jnv_pkg::CH_CR;
        endcase
    endfunction

    function automatic jnv_pkg::cp_t random_char();
        case ($urandom_range(0, 4))
            0: return jnv_pkg::cp_t'($urandom_range(0, 21'h10FFFF));
            1: return jnv_pkg::cp_t'($urandom_range(0, 127));
            2: return random_blank();
            3:
                case ($urandom_range(0, 6))
                    0: return jnv_pkg::CH_MINUS;
                    1: return jnv_pkg::CH_PLUS;
                    2: return jnv_pkg::CH_DOT;
                    3: return jnv_pkg::CH_LO_E;
                    4: return jnv_pkg::CH_UP_E;
                    5: return jnv_pkg::CH_COMMA;
                    default: return jnv_pkg::CH_RBRK;
                endcase
            default: return random_digit(0);
        endcase
    endfunction

    // Queue the characters in text_buf as one run of requests
    task automatic queue_value(input logic mark_last, input logic fresh);
        jnv_pkg::item_t ch;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            ch.code_point = text_buf[i];
            ch.first      = fresh && (i == 0);
            ch.last       = mark_last && (i == text_buf.size() - 1);
            pending_chars.push_back(ch);
        end
    endtask

    task automatic queue_text(input string s, input logic mark_last);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back({13'd0, s[i]});
        queue_value(mark_last, 1'b1);
    endtask

    // Build a well-formed number with random parts, then break some of them
    task automatic build_value();
        int pos;
        text_buf.delete();
        repeat ($urandom_range(0, 2))
            if ($urandom_range(0, 2) == 0)
                text_buf.push_back(random_blank());
        if ($urandom_range(0, 2) == 0)
            text_buf.push_back(jnv_pkg::CH_MINUS);
        if ($urandom_range(0, 3) == 0)
        begin
            text_buf.push_back(jnv_pkg::CH_ZERO);
        end
        else
        begin
            text_buf.push_back(random_digit(1));
            repeat ($urandom_range(0, 3))
                text_buf.push_back(random_digit(0));
        end
        if ($urandom_range(0, 2) == 0)
        begin
            text_buf.push_back(jnv_pkg::CH_DOT);
            repeat ($urandom_range(1, 3))
                text_buf.push_back(random_digit(0));
        end
        if ($urandom_range(0, 2) == 0)
        begin
            text_buf.push_back($urandom_range(0, 1) ? jnv_pkg::CH_LO_E : jnv_pkg::CH_UP_E);
            case ($urandom_range(0, 2))
                0: text_buf.push_back(jnv_pkg::CH_PLUS);
                1: text_buf.push_back(jnv_pkg::CH_MINUS);
                default: ;
            endcase
            repeat ($urandom_range(1, 3))
                text_buf.push_back(random_digit(0));
        end
        repeat ($urandom_range(0, 2))
            if ($urandom_range(0, 2) == 0)
                text_buf.push_back(random_blank());
        // Corrupt about a third of the values
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 11))
            0: if (text_buf.size() > 1) void'(text_buf.pop_back());
            1: text_buf[pos] = random_char();
            2: text_buf.insert(pos, random_char());
            3:
            begin
                text_buf.delete();
                repeat ($urandom_range(1, 4))
                    text_buf.push_back(random_char());
            end
            default: ;
        endcase
    endtask

    task automatic write_limit(input jnv_pkg::limit_t v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        scan_limit = v;
    endtask

    // Hold until every request is taken and every verdict is back
    task automatic wait_for_drain();
        while ((pending_chars.size() != 0) || chars_in.valid || (expected_verdicts.size() != 0))
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Stimulus: reset, directed values, then random phases under several limits
    initial
    begin
        int   phase_no;
        int   phase_items;
        logic mark_last;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        rst_n    <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed values under the reset limit
        queue_text("-0.5E-7]", 1'b0);
        queue_text(" 10e5 ,", 1'b0);
        queue_text("1.", 1'b1);
        queue_text(",", 1'b0);
        queue_text("- ", 1'b0);
        queue_text("7\tx", 1'b0);
        queue_text(" ", 1'b1);
        text_buf.delete();
        text_buf.push_back(21'h10FFFF);
        text_buf.push_back(21'h0F0000);
        queue_value(1'b0, 1'b1);
        wait_for_drain();

        for (phase_no = 0; phase_no < 6; phase_no++)
        begin
            case (phase_no)
                0: write_limit(16'd1);
                1: write_limit(16'hFFFF);
                2: write_limit(16'd3);
                3: write_limit(jnv_pkg::limit_t'($urandom_range(2, 12)));
                4: write_limit(jnv_pkg::limit_t'($urandom_range(13, 60)));
                default: write_limit(16'd256);
            endcase
            @(negedge clk);
            if (phase_no == 1)
                holdoff_go = 1'b1;
            if (phase_no == 5)
                idle_on = 1'b0;
            phase_items = 0;
            while (phase_items < 82)
            begin
                build_value();
                mark_last = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 5))
                    0: text_buf.push_back(jnv_pkg::CH_COMMA);
                    1: text_buf.push_back(jnv_pkg::CH_RBRK);
                    2, 3: mark_last = 1'b1;
                    default: ;
                endcase
                phase_items += text_buf.size();
                queue_value(mark_last, 1'b1);
                // Stray characters after the value without a restart
                if ($urandom_range(0, 7) == 0)
                begin
                    text_buf.delete();
                    repeat ($urandom_range(1, 2))
                        text_buf.push_back(random_char());
                    queue_value(1'b0, 1'b0);
                end
            end
            wait_for_drain();
        end

        if (expected_verdicts.size() != 0)
            flag_error($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
